// ----- hw/rtl/pcbp_pkg.sv -----
// Package: shared types and constants for the prefix code byte packer.
package pcbp_pkg;

  localparam int unsigned NUM_SYMBOLS = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PEND_W      = 7;
  localparam int unsigned PCNT_W      = 3;

  typedef logic [1:0]        symbol_t;
  typedef logic [3:0]        code_word_t;
  typedef logic [2:0]        code_len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    REG_WORD_SYM0 = 3'd0,
    REG_LEN_SYM0  = 3'd1,
    REG_WORD_SYM1 = 3'd2,
    REG_LEN_SYM1  = 3'd3,
    REG_WORD_SYM2 = 3'd4,
    REG_LEN_SYM2  = 3'd5,
    REG_WORD_SYM3 = 3'd6,
    REG_LEN_SYM3  = 3'd7
  } reg_index_t;

  localparam code_word_t WORD_RESET [NUM_SYMBOLS] = '{4'd2, 4'd1, 4'd6, 4'd14};
  localparam code_len_t  LEN_RESET  [NUM_SYMBOLS] = '{3'd2, 3'd2, 3'd3, 3'd4};

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_word_t;

  // Up to two output words per symbol; first goes out before second.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } enc_result_t;

endpackage

// ----- hw/rtl/pcbp_encode.sv -----
// Encoder datapath: appends one code to the pending bits and forms output words.
module pcbp_encode #(
  parameter int unsigned MAX_CODE_LEN = 4
) (
  input  pcbp_pkg::code_word_t          code_word,
  input  pcbp_pkg::code_len_t           code_len,
  input  logic                          end_of_message,
  input  logic [pcbp_pkg::PEND_W-1:0]   pending_bits,
  input  logic [pcbp_pkg::PCNT_W-1:0]   pending_count,
  output pcbp_pkg::enc_result_t         result,
  output logic [pcbp_pkg::PEND_W-1:0]   pending_bits_next,
  output logic [pcbp_pkg::PCNT_W-1:0]   pending_count_next
);

  localparam int unsigned ACC_W   = pcbp_pkg::PEND_W + MAX_CODE_LEN;
  localparam int unsigned CNT_W   = $clog2(ACC_W + 1);
  localparam int unsigned CAP_INT = (MAX_CODE_LEN > 7) ? 7 : MAX_CODE_LEN;
  localparam pcbp_pkg::code_len_t LEN_CAP = pcbp_pkg::code_len_t'(CAP_INT);
  localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(pcbp_pkg::BYTE_W);

  pcbp_pkg::code_len_t len_eff;
  logic [ACC_W-1:0]    word_ext;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_rem;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rem;
  logic                full;
  logic [3:0]          pad_shift;
  logic [14:0]         pad_wide;
  pcbp_pkg::byte_t     full_byte;
  pcbp_pkg::byte_t     pad_byte;
  logic                has_pad;

  always_comb begin
    len_eff   = (code_len > LEN_CAP) ? LEN_CAP : code_len;
    word_ext  = ACC_W'(code_word) & ~({ACC_W{1'b1}} << len_eff);
    acc       = (ACC_W'(pending_bits) << len_eff) | word_ext;
    count     = CNT_W'(pending_count) + CNT_W'(len_eff);
    full      = (count >= BYTE_CNT);
    full_byte = pcbp_pkg::byte_t'(acc >> (count - BYTE_CNT));
    rem       = full ? (count - BYTE_CNT) : count;
    acc_rem   = acc & ~({ACC_W{1'b1}} << rem);
    pad_shift = 4'd8 - {1'b0, rem[2:0]};
    pad_wide  = 15'(acc_rem[pcbp_pkg::PEND_W-1:0]) << pad_shift;
    pad_byte  = pad_wide[7:0];
    has_pad   = end_of_message && (rem[2:0] != 3'd0);
  end

  always_comb begin
    result = '0;
    priority if (full && has_pad) begin
      result.count  = 2'd2;
      result.first  = '{data: full_byte, last: 1'b0};
      result.second = '{data: pad_byte, last: 1'b1};
    end else if (full) begin
      result.count = 2'd1;
      result.first = '{data: full_byte, last: end_of_message};
    end else if (has_pad) begin
      result.count = 2'd1;
      result.first = '{data: pad_byte, last: 1'b1};
    end else begin
      result.count = 2'd0;
    end
  end

  assign pending_bits_next  = end_of_message ? '0 : acc_rem[pcbp_pkg::PEND_W-1:0];
  assign pending_count_next = end_of_message ? '0 : rem[pcbp_pkg::PCNT_W-1:0];

endmodule

// ----- hw/rtl/prefix_code_byte_packer_unit.sv -----
// Top level: prefix code encoder with byte packer, config registers, output queue.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid/tready          | tdata[1:0] symbol, tlast end_of_message
//  m_axis   | out | tvalid/tready          | tdata[7:0] packed_byte, tlast last_byte
//  cfg      | in  | cfg_we (no wait)       | cfg_index register, cfg_data value
//
// One symbol per cycle while s_axis_tready is high; it is encoded in the accepting cycle
// and its 0..2 words land in a 4-word output queue, registered before m_axis.
// s_axis_tready is high while at least two queue slots are free.
// rst (synchronous) empties the queue and pending bits and reloads the
// default code table. A stalled m_axis backs up into s_axis only via the queue.
module prefix_code_byte_packer_unit #(
  parameter int unsigned MAX_CODE_LEN = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] symbol, [7:2] zero
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] packed_byte
  output logic       m_axis_tlast,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = PTR_W + 1;

  pcbp_pkg::code_word_t code_word [pcbp_pkg::NUM_SYMBOLS];
  pcbp_pkg::code_len_t  code_len  [pcbp_pkg::NUM_SYMBOLS];

  logic [pcbp_pkg::PEND_W-1:0] pending_bits, pending_bits_next;
  logic [pcbp_pkg::PCNT_W-1:0] pending_count, pending_count_next;

  pcbp_pkg::out_word_t queue [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [FILL_W-1:0]   fill, fill_next;

  pcbp_pkg::symbol_t     symbol;
  pcbp_pkg::enc_result_t result;
  logic                  in_fire, out_fire;
  logic [1:0]            push_count;

  assign symbol = s_axis_tdata[1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcbp_pkg::NUM_SYMBOLS; i++) begin
        code_word[i] <= pcbp_pkg::WORD_RESET[i];
        code_len[i]  <= pcbp_pkg::LEN_RESET[i];
      end
    end else if (cfg_we) begin
      unique case (pcbp_pkg::reg_index_t'(cfg_index))
        pcbp_pkg::REG_WORD_SYM0: code_word[0] <= cfg_data;
        pcbp_pkg::REG_LEN_SYM0:  code_len[0]  <= cfg_data[2:0];
        pcbp_pkg::REG_WORD_SYM1: code_word[1] <= cfg_data;
        pcbp_pkg::REG_LEN_SYM1:  code_len[1]  <= cfg_data[2:0];
        pcbp_pkg::REG_WORD_SYM2: code_word[2] <= cfg_data;
        pcbp_pkg::REG_LEN_SYM2:  code_len[2]  <= cfg_data[2:0];
        pcbp_pkg::REG_WORD_SYM3: code_word[3] <= cfg_data;
        pcbp_pkg::REG_LEN_SYM3:  code_len[3]  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pcbp_encode #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_encode (
    .code_word          (code_word[symbol]),
    .code_len           (code_len[symbol]),
    .end_of_message     (s_axis_tlast),
    .pending_bits       (pending_bits),
    .pending_count      (pending_count),
    .result             (result),
    .pending_bits_next  (pending_bits_next),
    .pending_count_next (pending_count_next)
  );

  assign s_axis_tready = (fill <= FILL_W'(DEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign push_count    = in_fire ? result.count : 2'd0;
  assign fill_next     = fill + FILL_W'(push_count) - FILL_W'(out_fire);

  assign m_axis_tdata = queue[rd_ptr].data;
  assign m_axis_tlast = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fill          <= '0;
    end else begin
      if (in_fire) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(out_fire);
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue[wr_ptr] <= result.first;
    end
    if (push_count == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= result.second;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("output queue overfilled");

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tlast |=> pending_count == '0 && pending_bits == '0)
    else $error("pending bits survive end of message");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    !in_fire && !out_fire |=> $stable(fill))
    else $error("queue fill changed without a transfer");

  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && result.count == 2'd2 |-> result.second.last && !result.first.last)
    else $error("flush word ordering wrong");

  a_pending_mask: assert property (@(posedge clk) disable iff (rst)
    pending_count != 3'd7 |-> (pending_bits >> pending_count) == '0)
    else $error("stale bits above pending count");

endmodule

// ----- tb/sv/prefix_code_byte_packer_checker.sv -----
// Checker for the prefix code byte packer: predicts packed bytes and compares them.
module prefix_code_byte_packer_checker #(
  parameter int unsigned MAX_CODE_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int unsigned mismatches,
  output int unsigned words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  pcbp_pkg::code_word_t        sym_word [pcbp_pkg::NUM_SYMBOLS];
  pcbp_pkg::code_len_t         sym_len  [pcbp_pkg::NUM_SYMBOLS];
  logic [pcbp_pkg::PEND_W-1:0] held_bits;
  logic [pcbp_pkg::PCNT_W-1:0] held_count;
  pcbp_pkg::out_word_t         expected_words [$];
  int unsigned                 fail_count = 0;

  function automatic void encode_symbol(pcbp_pkg::symbol_t sym, logic eom);
    logic [11:0]         acc;
    int unsigned         len;
    int unsigned         count;
    bit                  emitted;
    pcbp_pkg::out_word_t w;
    len = sym_len[sym];
    if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
    acc = (12'(held_bits) << len) | (12'(sym_word[sym]) & ((12'd1 << len) - 12'd1));
    count = held_count + len;
    emitted = 1'b0;
    if (count >= pcbp_pkg::BYTE_W) begin
      w.data = pcbp_pkg::byte_t'(acc >> (count - pcbp_pkg::BYTE_W));
      w.last = 1'b0;
      expected_words.push_back(w);
      emitted = 1'b1;
      count -= pcbp_pkg::BYTE_W;
      acc &= (12'd1 << count) - 12'd1;
    end
    if (eom) begin
      if (count > 0) begin
        w.data = pcbp_pkg::byte_t'(acc << (pcbp_pkg::BYTE_W - count));
        w.last = 1'b1;
        expected_words.push_back(w);
      end else if (emitted) begin
        // byte boundary: the full byte itself closes the message
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      acc = '0;
      count = 0;
    end
    held_bits = acc[pcbp_pkg::PEND_W-1:0];
    held_count = count[pcbp_pkg::PCNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    pcbp_pkg::out_word_t want;
    if (rst) begin
      for (int k = 0; k < pcbp_pkg::NUM_SYMBOLS; k++) begin
        sym_word[k] = pcbp_pkg::WORD_RESET[k];
        sym_len[k] = pcbp_pkg::LEN_RESET[k];
      end
      held_bits = '0;
      held_count = '0;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word data=%02h last=%0b", $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: data mismatch expected=%02h actual=%02h", $time, want.data, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last mismatch expected=%0b actual=%0b", $time, want.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        // odd index = code length, even index = code word
        if (cfg_index[0]) sym_len[cfg_index[2:1]] = cfg_data[2:0];
        else sym_word[cfg_index[2:1]] = cfg_data;
      end
      if (s_tvalid && s_tready) encode_symbol(pcbp_pkg::symbol_t'(s_tdata[1:0]), s_tlast);
    end
    mismatches <= fail_count;
    words_due <= expected_words.size();
  end

endmodule

// ----- tb/sv/tb_prefix_code_byte_packer_unit.sv -----
// Testbench top: drives symbols, code tables and output stalls into the byte packer.
module tb_prefix_code_byte_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CODE_LEN_LIMIT = 4;
  localparam int unsigned PHASE_ITEMS    = 230;
  localparam int unsigned SILENT_ITEMS   = 40;
  localparam int unsigned NUM_PHASES     = 8;
  localparam logic [31:0] DEFAULT_IMAGE  = 32'h4E36_2122;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;
  int unsigned mismatches;
  int unsigned words_due;

  prefix_code_byte_packer_unit #(.MAX_CODE_LEN(CODE_LEN_LIMIT)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prefix_code_byte_packer_checker #(.MAX_CODE_LEN(CODE_LEN_LIMIT)) pack_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tlast(s_axis_tlast),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** prefix_code_byte_packer_unit: FAILED **");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_msg_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 20);
    return $urandom_range(21, 60);
  endfunction

  // nibble i of the image is the value for register i
  function automatic logic [31:0] phase_image(int unsigned p);
    logic [31:0] img;
    img = $urandom();
    unique case (p)
      0: img = 32'h4F4F_4F4F;
      1: for (int k = 0; k < pcbp_pkg::NUM_SYMBOLS; k++)
           img[8*k+4 +: 4] = {1'($urandom_range(0, 1)), 3'(4 + k)};
      2: for (int k = 0; k < pcbp_pkg::NUM_SYMBOLS; k++)
           img[8*k+4 +: 4] = {1'($urandom_range(0, 1)), 3'd1};
      3: for (int k = 0; k < pcbp_pkg::NUM_SYMBOLS; k++)
           img[8*k+4 +: 4] = {1'($urandom_range(0, 1)), 3'd0};
      7: img = DEFAULT_IMAGE;
      default: ;
    endcase
    return img;
  endfunction

  task automatic send_symbol(pcbp_pkg::symbol_t sym, logic eom);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, sym};
    s_axis_tlast <= eom;
    do @(posedge clk); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] reg_image);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= pcbp_pkg::reg_index_t'(i);
      cfg_data <= reg_image[4*i +: 4];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(int unsigned n);
    pcbp_pkg::symbol_t run_sym;
    bit                run_mode;
    run_mode = ($urandom_range(0, 9) == 0);
    run_sym = pcbp_pkg::symbol_t'($urandom_range(0, 3));
    for (int unsigned i = 0; i < n; i++)
      send_symbol(run_mode ? run_sym : pcbp_pkg::symbol_t'($urandom_range(0, 3)), i == n - 1);
  endtask

  initial begin
    int unsigned r;
    int unsigned burst;
    int unsigned hold;
    int unsigned rounds;
    m_axis_tready <= 1'b0;
    rounds = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rounds++;
      r = $urandom_range(0, 99);
      burst = (r < 10) ? $urandom_range(40, 80) : $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      r = $urandom_range(0, 99);
      if (rounds == 40) hold = 250;
      else if (r < 45) hold = 0;
      else if (r < 85) hold = $urandom_range(1, 4);
      else if (r < 97) hold = $urandom_range(5, 15);
      else hold = $urandom_range(20, 40);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned quota;
    int unsigned sent;
    int unsigned n;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= pcbp_pkg::REG_WORD_SYM0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default table: partial bytes, boundary flush, full byte plus padded flush
    send_symbol(2'd1, 1'b0); send_symbol(2'd2, 1'b0); send_symbol(2'd3, 1'b0);
    send_symbol(2'd0, 1'b0); send_symbol(2'd3, 1'b1);
    send_symbol(2'd0, 1'b0); send_symbol(2'd0, 1'b0); send_symbol(2'd0, 1'b0);
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd2, 1'b0); send_symbol(2'd2, 1'b0); send_symbol(2'd2, 1'b1);
    send_symbol(2'd3, 1'b0); send_symbol(2'd3, 1'b1);
    send_symbol(2'd0, 1'b1);

    // zero length, clamped length, word bits above the length
    settle();
    load_regs(32'h987F_408F);
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd0, 1'b0); send_symbol(2'd2, 1'b0); send_symbol(2'd2, 1'b1);
    send_symbol(2'd3, 1'b0); send_symbol(2'd3, 1'b0); send_symbol(2'd1, 1'b0);
    send_symbol(2'd3, 1'b1);
    send_symbol(2'd1, 1'b0); send_symbol(2'd1, 1'b0); send_symbol(2'd0, 1'b1);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_regs(phase_image(p));
      quota = (p == 3) ? SILENT_ITEMS : PHASE_ITEMS;
      sent = 0;
      while (sent < quota) begin
        n = pick_msg_len();
        send_message(n);
        sent += n;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** prefix_code_byte_packer_unit: PASSED **");
    end else begin
      $display("** prefix_code_byte_packer_unit: FAILED **");
    end
    $finish;
  end

endmodule
